/* sv/lacdz_pkg.sv */
// Package for the lateral anchor dead-zone correction block.
// Holds fixed-point constants, the pipeline word type and rounding and saturation helpers.
// No dependencies.
package lacdz_pkg;

   localparam int FRAC_BITS = 16;
   localparam int SC_BITS   = 28;
   localparam int STEPS     = 6;
   localparam int NST       = 33;
   localparam int LAT       = NST;

   localparam logic signed [31:0] PI_Q      = 32'sd843314857;
   localparam logic signed [31:0] TWO_PI_Q  = 32'sd1686629713;
   localparam logic signed [31:0] HALF_PI_Q = 32'sd421657428;
   localparam logic [29:0]        SC_ONE    = 30'd268435456;
   localparam logic [16:0]        GAIN_ONE  = 17'd65536;
   localparam logic [22:0]        VAR_LIMIT = 23'd4194304;

   localparam logic [7:0] CSR_BALANCE = 8'd0;
   localparam logic [7:0] CSR_CORNER  = 8'd1;

   localparam logic [7:0]  SIN_K   [STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6, 8'd0};
   localparam logic [7:0]  COS_K   [STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
   localparam logic [31:0] SIN_RCP [STEPS] = '{32'd39045157, 32'd59652323, 32'd102261126,
                                              32'd214748364, 32'd715827882, 32'd0};
   localparam logic [31:0] COS_RCP [STEPS] = '{32'd32537631, 32'd47721858, 32'd76695844,
                                              32'd143165576, 32'd357913941, 32'd2147483648};

   typedef struct packed {
      logic signed [18:0] yaw;
      logic        [20:0] tw;
      logic        [20:0] ow;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic        [16:0] alpha;
      logic        [16:0] beta;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [21:0] s2;
      logic        [28:0] m;
      logic               rneg;
      logic               negc;
      logic        [57:0] msq;
      logic        [29:0] x2;
      logic signed [29:0] ts;
      logic signed [29:0] tc;
      logic        [29:0] ps;
      logic        [29:0] pc;
      logic        [29:0] qs;
      logic        [29:0] qc;
      logic signed [29:0] sn;
      logic signed [29:0] cs;
      logic signed [63:0] pr1;
      logic signed [63:0] pr2;
      logic signed [34:0] d;
      logic        [35:0] a2;
      logic        [20:0] mn;
      logic        [35:0] excess;
      logic        [37:0] pa;
      logic        [37:0] pb;
      logic signed [55:0] lm;
      logic        [37:0] stdx;
      logic signed [38:0] mv;
      logic        [21:0] std2;
      logic signed [68:0] mx;
      logic signed [68:0] my;
      logic        [43:0] sq;
      logic signed [40:0] offx;
      logic signed [40:0] offy;
      logic        [22:0] var_q;
      logic signed [31:0] outx;
      logic signed [31:0] outy;
   } item_type;

   function automatic logic signed [71:0] rnd_shift(input logic signed [71:0] v,
                                                     input int sh);
      logic signed [71:0] half;
      half = 72'sd1 <<< (sh - 1);
      if (v < 0) return (v + half - 72'sd1) >>> sh;
      else return (v + half) >>> sh;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
      if (v > 42'sd2147483647) return 32'sh7FFFFFFF;
      else if (v < -42'sd2147483648) return 32'sh80000000;
      else return v[31:0];
   endfunction

endpackage

/* sv/lateral_anchor_deadzone_correct.sv */
// Top level of the lateral anchor dead-zone correction pipeline.
// Depends on lacdz_pkg.
//
// One word enters per cycle and its result appears on the rsp_ ports, strobed
// by rsp_valid, once it has passed every pipeline stage register. The depth is set by the
// six Horner steps of the sine and cosine (three register stages each: product,
// reciprocal product, correction) plus the projection, dead-zone and variance
// stages. busy is high only in reset; the receiver cannot stall the pipeline.
module lateral_anchor_deadzone_correct
   import lacdz_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [18:0] req_body_yaw,
   input  logic        [20:0] req_tracked_width,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic        [20:0] req_observed_width,
   input  logic signed [31:0] req_anchor_x,
   input  logic signed [31:0] req_anchor_y,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_corrected_x,
   output logic signed [31:0] rsp_corrected_y,
   output logic        [22:0] rsp_lateral_variance,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [7:0]  csr_index,
   input  logic        [16:0] csr_wdata
);

   item_type     st_ff [NST];
   item_type     st_in [NST];
   logic [NST-1:0] vld_ff;
   logic [16:0]  balance_ff;
   logic [16:0]  corner_ff;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         balance_ff <= 17'd32768;
         corner_ff  <= 17'd32768;
      end else begin
         vld_ff <= {vld_ff[NST-2:0], start & ~busy};
         if (csr_valid && csr_index == CSR_BALANCE) balance_ff <= csr_wdata;
         if (csr_valid && csr_index == CSR_CORNER)  corner_ff  <= csr_wdata;
      end
      st_ff <= st_in;
   end

   // capture
   always_comb begin
      st_in[0]       = '0;
      st_in[0].yaw   = req_body_yaw;
      st_in[0].tw    = req_tracked_width;
      st_in[0].ow    = req_observed_width;
      st_in[0].cx    = req_center_x;
      st_in[0].cy    = req_center_y;
      st_in[0].ax    = req_anchor_x;
      st_in[0].ay    = req_anchor_y;
      st_in[0].alpha = (balance_ff > GAIN_ONE) ? GAIN_ONE : balance_ff;
      st_in[0].beta  = (corner_ff > GAIN_ONE) ? GAIN_ONE : corner_ff;
   end

   // angle reduction and fold
   always_comb begin
      logic signed [31:0] v;
      logic signed [31:0] r;
      logic               nc;
      st_in[1] = st_ff[0];
      v = 32'(st_ff[0].yaw) <<< (SC_BITS - FRAC_BITS);
      if (v > PI_Q) r = v - TWO_PI_Q;
      else if (v < -PI_Q) r = v + TWO_PI_Q;
      else r = v;
      nc = 1'b0;
      if (r > HALF_PI_Q) begin
         r  = PI_Q - r;
         nc = 1'b1;
      end else if (r < -HALF_PI_Q) begin
         r  = -PI_Q - r;
         nc = 1'b1;
      end
      st_in[1].negc = nc;
      st_in[1].rneg = r < 0;
      st_in[1].m    = (r < 0) ? 29'(-r) : 29'(r);
      st_in[1].s2   = $signed({1'b0, st_ff[0].ow}) - $signed({1'b0, st_ff[0].tw});
      st_in[1].dx   = 33'(st_ff[0].ax) - 33'(st_ff[0].cx);
      st_in[1].dy   = 33'(st_ff[0].ay) - 33'(st_ff[0].cy);
   end

   always_comb begin
      st_in[2]     = st_ff[1];
      st_in[2].msq = 58'(st_ff[1].m) * 58'(st_ff[1].m);
   end

   always_comb begin
      st_in[3]    = st_ff[2];
      st_in[3].x2 = 30'((st_ff[2].msq + 58'd134217728) >> SC_BITS);
      st_in[3].ts = $signed(SC_ONE);
      st_in[3].tc = $signed(SC_ONE);
   end

   // Horner steps: product, reciprocal product, correction
   for (genvar j = 0; j < STEPS; j++) begin : g_step
      localparam int IA = 4 + 3 * j;

      always_comb begin
         st_in[IA]    = st_ff[IA-1];
         st_in[IA].ps = 30'((59'(st_ff[IA-1].x2) * 59'(st_ff[IA-1].ts[28:0])) >> SC_BITS);
         st_in[IA].pc = 30'((59'(st_ff[IA-1].x2) * 59'(st_ff[IA-1].tc[28:0])) >> SC_BITS);
      end

      always_comb begin
         st_in[IA+1]    = st_ff[IA];
         st_in[IA+1].qs = 30'((62'(st_ff[IA].ps) * 62'(SIN_RCP[j])) >> 32);
         st_in[IA+1].qc = 30'((62'(st_ff[IA].pc) * 62'(COS_RCP[j])) >> 32);
      end

      always_comb begin
         logic [29:0] rs;
         logic [29:0] rc;
         logic [29:0] q1;
         logic [29:0] q2;
         st_in[IA+2] = st_ff[IA+1];
         rs = st_ff[IA+1].ps - 30'(st_ff[IA+1].qs * 30'(SIN_K[j]));
         rc = st_ff[IA+1].pc - 30'(st_ff[IA+1].qc * 30'(COS_K[j]));
         q1 = st_ff[IA+1].qs + ((rs >= 30'(SIN_K[j])) ? 30'd1 : 30'd0);
         q2 = st_ff[IA+1].qc + ((rc >= 30'(COS_K[j])) ? 30'd1 : 30'd0);
         if (SIN_K[j] != 8'd0) st_in[IA+2].ts = $signed(SC_ONE - q1);
         st_in[IA+2].tc = $signed(SC_ONE - q2);
      end
   end

   // sine and cosine
   always_comb begin
      logic [28:0] sv;
      logic signed [29:0] cv;
      st_in[22] = st_ff[21];
      sv = 29'((58'(st_ff[21].m) * 58'(st_ff[21].ts[28:0])) >> SC_BITS);
      cv = (st_ff[21].tc < 0) ? 30'sd0 : st_ff[21].tc;
      st_in[22].sn = st_ff[21].rneg ? -$signed({1'b0, sv}) : $signed({1'b0, sv});
      st_in[22].cs = st_ff[21].negc ? -cv : cv;
   end

   always_comb begin
      st_in[23]     = st_ff[22];
      st_in[23].pr1 = (-64'(st_ff[22].dx)) * 64'(st_ff[22].sn);
      st_in[23].pr2 = 64'(st_ff[22].dy) * 64'(st_ff[22].cs);
   end

   always_comb begin
      logic signed [71:0] rd;
      st_in[24]   = st_ff[23];
      rd          = rnd_shift(72'(st_ff[23].pr1 + st_ff[23].pr2), SC_BITS);
      st_in[24].d = rd[34:0];
   end

   always_comb begin
      logic signed [34:0] ad;
      st_in[25]    = st_ff[24];
      ad           = (st_ff[24].d < 0) ? -st_ff[24].d : st_ff[24].d;
      st_in[25].a2 = {ad, 1'b0};
   end

   always_comb begin
      logic [35:0] s2u;
      st_in[26] = st_ff[25];
      s2u = (st_ff[25].s2 > 0) ? 36'(st_ff[25].s2[20:0]) : 36'd0;
      if (st_ff[25].a2 <= s2u) begin
         st_in[26].mn     = st_ff[25].a2[20:0];
         st_in[26].excess = '0;
      end else begin
         st_in[26].mn     = s2u[20:0];
         st_in[26].excess = st_ff[25].a2 - s2u;
      end
   end

   always_comb begin
      st_in[27]    = st_ff[26];
      st_in[27].pa = 38'(st_ff[26].alpha) * 38'(st_ff[26].mn);
      st_in[27].pb = 38'(GAIN_ONE - st_ff[26].beta) * 38'(st_ff[26].mn);
   end

   always_comb begin
      logic signed [55:0] shx;
      st_in[28]      = st_ff[27];
      shx            = $signed(56'(st_ff[27].pa) + (56'(st_ff[27].excess) << 16));
      st_in[28].lm   = ((st_ff[27].d >= 0) ? shx : -shx) - (56'(st_ff[27].d) <<< 17);
      st_in[28].stdx = (38'(st_ff[27].s2[20:0]) << 16) - st_ff[27].pb;
   end

   always_comb begin
      logic signed [71:0] rm;
      logic        [37:0] rs;
      st_in[29]    = st_ff[28];
      rm           = rnd_shift(72'(st_ff[28].lm), 17);
      st_in[29].mv = rm[38:0];
      rs           = (st_ff[28].stdx + 38'd32768) >> 16;
      st_in[29].std2 = (st_ff[28].s2 <= 0) ? 22'(-st_ff[28].s2) : rs[21:0];
   end

   always_comb begin
      st_in[30]    = st_ff[29];
      st_in[30].mx = 69'(st_ff[29].mv) * 69'(st_ff[29].sn);
      st_in[30].my = 69'(st_ff[29].mv) * 69'(st_ff[29].cs);
      st_in[30].sq = 44'(st_ff[29].std2) * 44'(st_ff[29].std2);
   end

   always_comb begin
      logic signed [71:0] ox;
      logic signed [71:0] oy;
      logic        [43:0] vq;
      st_in[31]      = st_ff[30];
      ox             = rnd_shift(72'(st_ff[30].mx), SC_BITS);
      oy             = rnd_shift(72'(st_ff[30].my), SC_BITS);
      st_in[31].offx = ox[40:0];
      st_in[31].offy = oy[40:0];
      vq             = (st_ff[30].sq + 44'd131072) >> (FRAC_BITS + 2);
      st_in[31].var_q = (vq > 44'(VAR_LIMIT)) ? VAR_LIMIT : vq[22:0];
   end

   always_comb begin
      st_in[32] = st_ff[31];
      if (st_ff[31].s2 <= 0) begin
         st_in[32].outx = st_ff[31].ax;
         st_in[32].outy = st_ff[31].ay;
      end else begin
         st_in[32].outx = sat32(42'(st_ff[31].ax) - 42'(st_ff[31].offx));
         st_in[32].outy = sat32(42'(st_ff[31].ay) + 42'(st_ff[31].offy));
      end
   end

   assign rsp_valid            = vld_ff[NST-1];
   assign rsp_corrected_x      = st_ff[NST-1].outx;
   assign rsp_corrected_y      = st_ff[NST-1].outy;
   assign rsp_lateral_variance = st_ff[NST-1].var_q;

endmodule

/* sv/lacdz_chk.sv */
// Port-level checker for the lateral anchor dead-zone correction block.
// Depends on lacdz_pkg; bound to lateral_anchor_deadzone_correct below.
module lacdz_chk
   import lacdz_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic        [20:0] req_tracked_width,
   input logic        [20:0] req_observed_width,
   input logic signed [31:0] req_anchor_x,
   input logic signed [31:0] req_anchor_y,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_corrected_x,
   input logic signed [31:0] rsp_corrected_y,
   input logic        [22:0] rsp_lateral_variance
);

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LAT rsp_valid)
      else $error("word accepted without result at fixed latency");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without matching word");

   a_partial: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_observed_width <= req_tracked_width, LAT)
      |-> rsp_corrected_x == $past(req_anchor_x, LAT)
          && rsp_corrected_y == $past(req_anchor_y, LAT))
      else $error("partial view did not pass anchor through");

   a_var_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_lateral_variance <= VAR_LIMIT)
      else $error("variance above limit");

endmodule

bind lateral_anchor_deadzone_correct lacdz_chk u_lacdz_chk (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_tracked_width   (req_tracked_width),
   .req_observed_width  (req_observed_width),
   .req_anchor_x        (req_anchor_x),
   .req_anchor_y        (req_anchor_y),
   .rsp_valid           (rsp_valid),
   .rsp_corrected_x     (rsp_corrected_x),
   .rsp_corrected_y     (rsp_corrected_y),
   .rsp_lateral_variance(rsp_lateral_variance)
);

/* dv/lateral_anchor_deadzone_correct_chk.sv */
// Checker for the lateral anchor dead-zone correction block: watches the
// request, response and register channels, predicts each response and compares.
// Depends on lacdz_pkg for the register indexes.
`timescale 1ns / 100ps
module lateral_anchor_deadzone_correct_chk
   import lacdz_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [18:0] req_body_yaw,
   input  logic        [20:0] req_tracked_width,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic        [20:0] req_observed_width,
   input  logic signed [31:0] req_anchor_x,
   input  logic signed [31:0] req_anchor_y,
   input  logic               rsp_valid,
   input  logic signed [31:0] rsp_corrected_x,
   input  logic signed [31:0] rsp_corrected_y,
   input  logic        [22:0] rsp_lateral_variance,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic        [7:0]  csr_index,
   input  logic        [16:0] csr_wdata,
   output int                 fail_count,
   output int                 pending
);

   typedef struct {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic        [22:0] var_q;
   } anchor_word_type;

   anchor_word_type corrections[$];
   logic    [16:0] slope_gain;
   logic    [16:0] residual_gain;

   assign pending = corrections.size();

   function automatic longint rnd(longint v, int sh);
      longint half;
      half = longint'(1) << (sh - 1);
      if (v >= 0) return (v + half) >>> sh;
      return -((-v + half) >>> sh);
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic [22:0] square_var(longint std2);
      longint q;
      q = (std2 * std2 + (longint'(1) << 17)) >>> 18;
      return (q > 4194304) ? 23'd4194304 : q[22:0];
   endfunction

   function automatic void trig(longint yaw, output longint sn, output longint cs);
      longint r, m, x2, t, sv, cv, one;
      int     sk[5];
      int     ck[6];
      bit     negc;
      sk = '{110, 72, 42, 20, 6};
      ck = '{132, 90, 56, 30, 12, 2};
      one = longint'(1) << 28;
      negc = 0;
      r = (yaw * 4096) % 64'sd1686629713;
      if (r > 843314857) r -= 1686629713;
      if (r < -843314857) r += 1686629713;
      if (r > 421657428) begin
         r = 843314857 - r;
         negc = 1;
      end else if (r < -421657428) begin
         r = -843314857 - r;
         negc = 1;
      end
      m = r < 0 ? -r : r;
      x2 = rnd(m * m, 28);
      t = one;
      for (int i = 0; i < 5; i++) t = one - ((x2 * t) >>> 28) / sk[i];
      sv = (m * t) >>> 28;
      t = one;
      for (int i = 0; i < 6; i++) t = one - ((x2 * t) >>> 28) / ck[i];
      cv = t < 0 ? 0 : t;
      sn = r < 0 ? -sv : sv;
      cs = negc ? -cv : cv;
   endfunction

   function automatic anchor_word_type correct_anchor(longint yaw, longint tw, longint cx,
                                                      longint cy, longint ow, longint ax,
                                                      longint ay);
      anchor_word_type w;
      longint al, be, s2, sn, cs, d, a2, shx, stdx, lm, mv;
      al = slope_gain > 65536 ? 65536 : slope_gain;
      be = residual_gain > 65536 ? 65536 : residual_gain;
      s2 = ow - tw;
      if (s2 <= 0) begin
         w.cx = clamp32(ax);
         w.cy = clamp32(ay);
         w.var_q = square_var(-s2);
         return w;
      end
      trig(yaw, sn, cs);
      d = rnd(-(ax - cx) * sn + (ay - cy) * cs, 28);
      a2 = 2 * (d < 0 ? -d : d);
      if (a2 <= s2) begin
         shx = al * a2;
         stdx = s2 * 65536 - (65536 - be) * a2;
      end else begin
         shx = (a2 - s2) * 65536 + al * s2;
         stdx = be * s2;
      end
      lm = (d >= 0 ? shx : -shx) - d * 131072;
      mv = rnd(lm, 17);
      w.cx = clamp32(ax - rnd(mv * sn, 28));
      w.cy = clamp32(ay + rnd(mv * cs, 28));
      w.var_q = square_var(rnd(stdx, 16));
      return w;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      anchor_word_type w;
      if (reset) begin
         fail_count = 0;
         slope_gain <= 17'd32768;
         residual_gain <= 17'd32768;
      end else begin
         if (rsp_valid) begin
            if (corrections.size() == 0) begin
               report("unexpected word", rsp_corrected_x, 0);
            end else begin
               w = corrections.pop_front();
               if (rsp_corrected_x !== w.cx) report("corrected_x", rsp_corrected_x, w.cx);
               if (rsp_corrected_y !== w.cy) report("corrected_y", rsp_corrected_y, w.cy);
               if (rsp_lateral_variance !== w.var_q)
                  report("lateral_variance", rsp_lateral_variance, w.var_q);
            end
         end
         if (start && !busy)
            corrections.push_back(correct_anchor(req_body_yaw, req_tracked_width,
               req_center_x, req_center_y, req_observed_width, req_anchor_x,
               req_anchor_y));
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BALANCE) slope_gain <= csr_wdata;
            else if (csr_index == CSR_CORNER) residual_gain <= csr_wdata;
         end
      end
   end

endmodule

/* dv/lateral_anchor_deadzone_correct_tb.sv */
// Testbench top for the lateral anchor dead-zone correction block: drives
// directed and random words and register settings, and gives the verdict.
// Depends on lacdz_pkg, lateral_anchor_deadzone_correct and lateral_anchor_deadzone_correct_chk.
`timescale 1ns / 100ps
module lateral_anchor_deadzone_correct_tb;
   import lacdz_pkg::*;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [18:0] req_body_yaw;
   logic        [20:0] req_tracked_width;
   logic signed [31:0] req_center_x;
   logic signed [31:0] req_center_y;
   logic        [20:0] req_observed_width;
   logic signed [31:0] req_anchor_x;
   logic signed [31:0] req_anchor_y;
   logic               rsp_valid;
   logic signed [31:0] rsp_corrected_x;
   logic signed [31:0] rsp_corrected_y;
   logic        [22:0] rsp_lateral_variance;
   logic               csr_valid;
   logic               csr_ready;
   logic        [7:0]  csr_index;
   logic        [16:0] csr_wdata;
   int                 fail_count;
   int                 pending;
   bit                 calm;

   lateral_anchor_deadzone_correct u_dut (.*);
   lateral_anchor_deadzone_correct_chk u_chk (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   task automatic send_word(logic [18:0] yaw, logic [20:0] tw, logic [31:0] cx,
                            logic [31:0] cy, logic [20:0] ow, logic [31:0] ax,
                            logic [31:0] ay);
      while (!calm && $urandom_range(99) < 21) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_body_yaw <= yaw;
      req_tracked_width <= tw;
      req_center_x <= cx;
      req_center_y <= cy;
      req_observed_width <= ow;
      req_anchor_x <= ax;
      req_anchor_y <= ay;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LAT + 4) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, logic [16:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_word();
      logic [31:0] cx, cy, ax, ay;
      logic [20:0] tw, ow;
      cx = $urandom;
      cy = $urandom;
      if ($urandom_range(9) < 7) begin
         cx = $signed(cx) >>> $urandom_range(12, 0);
         cy = $signed(cy) >>> $urandom_range(12, 0);
         ax = cx + ($signed($urandom) >>> $urandom_range(20, 10));
         ay = cy + ($signed($urandom) >>> $urandom_range(20, 10));
      end else begin
         ax = $urandom;
         ay = $urandom;
      end
      tw = 21'($urandom_range(2097151));
      ow = 21'($urandom_range(2097151));
      if ($urandom_range(9) < 7) begin
         tw = 21'($urandom_range(1048576));
         ow = 21'(32'(tw) + $urandom_range(200000));
      end
      send_word(19'($urandom), tw, cx, cy, ow, ax, ay);
   endtask

   initial begin
      #40000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      logic [16:0] gains[6];
      gains = '{17'd32768, 17'd0, 17'd65536, 17'd131071, 17'd12345, 17'd65535};
      reset <= 1'b1;
      start <= 1'b0;
      calm = 0;
      req_body_yaw <= '0;
      req_tracked_width <= '0;
      req_center_x <= '0;
      req_center_y <= '0;
      req_observed_width <= '0;
      req_anchor_x <= '0;
      req_anchor_y <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_BALANCE;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_word(19'sd0, 21'd65536, 32'sd0, 32'sd0, 21'd131072, 32'sd10000, 32'sd20000);
      send_word(19'sd205887, 21'd0, 32'sd0, 32'sd0, 21'd1048576, 32'sd70000, -32'sd90000);
      send_word(-19'sd205887, 21'd1048576, 32'sd5, 32'sd5, 21'd0, 32'sd1, 32'sd2);
      send_word(19'h3FFFF, 21'd1000, 32'sd0, 32'sd0, 21'd1000, 32'sd0, 32'sd0);
      send_word(19'h40000, 21'd1, 32'sd0, 32'sd0, 21'h1FFFFF, 32'h7FFFFFFF, 32'h80000000);
      send_word(19'sd102943, 21'd0, 32'h80000000, 32'h7FFFFFFF, 21'h1FFFFF,
                32'h7FFFFFFF, 32'h80000000);
      send_word(-19'sd102943, 21'h1FFFFF, 32'sd0, 32'sd0, 21'd0, 32'sd3, 32'sd3);
      send_word(19'sd51471, 21'd65536, 32'sd0, 32'sd0, 21'd196608, 32'sd0, 32'sd0);
      send_word(19'sd51471, 21'd65536, 32'sd100, 32'sd100, 21'd196608, -32'sd900000,
                32'sd900000);
      send_word(19'sd0, 21'd0, 32'sd0, 32'sd0, 21'd65536, 32'sd0, 32'sd16384);
      for (int p = 0; p < 6; p++) begin
         drain();
         write_reg(CSR_BALANCE, gains[p]);
         write_reg(CSR_CORNER, gains[5 - p]);
         if (p == 2) write_reg(8'd7, 17'd999);
         calm = (p == 3);
         repeat (160) random_word();
      end
      drain();
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/lacdz_pkg.sv
sv/lateral_anchor_deadzone_correct.sv
sv/lacdz_chk.sv
dv/lateral_anchor_deadzone_correct_chk.sv
dv/lateral_anchor_deadzone_correct_tb.sv
